[sv/atipd_pkg.sv]
// Package for the AT response and +IPD frame parser.
// Holds the op, mode, kind and response codes, the fixed reply texts and the prefix compare.
// No dependencies.
package atipd_pkg;

	localparam int unsigned LINE_DEPTH_DEF = 256;

	// Only the first bytes of a line are kept; no reply text is longer.
	localparam int unsigned PREFIX_LEN = 12;
	localparam int unsigned PREFIX_IW  = $clog2(PREFIX_LEN);

	localparam int unsigned IPD_LEN      = 5;
	localparam int unsigned OK_LEN       = 2;
	localparam int unsigned SEND_CMD_LEN = 11;
	localparam int unsigned SEND_MIN_LEN = 12;
	localparam int unsigned REPLY_NUM    = 8;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_CR    = 8'h0D;
	localparam logic [7:0] ASCII_LF    = 8'h0A;
	localparam logic [7:0] ASCII_NUL   = 8'h00;
	localparam logic [7:0] KEY_COMMA   = 8'h2C;
	localparam logic [7:0] KEY_COLON   = 8'h3A;
	localparam logic [7:0] KEY_PROMPT  = 8'h3E;

	typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;

	typedef enum logic [1:0] {
		OP_BYTE      = 2'd0,
		OP_ARM_SEND  = 2'd1,
		OP_FORCE_CMD = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		MODE_LINES   = 3'd0,
		MODE_ID      = 3'd1,
		MODE_LEN     = 3'd2,
		MODE_PAYLOAD = 3'd3,
		MODE_PROMPT  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		KIND_RESPONSE = 2'd0,
		KIND_HEADER   = 2'd1,
		KIND_PAYLOAD  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		RESP_READY       = 4'd0,
		RESP_OK          = 4'd1,
		RESP_ERROR       = 4'd2,
		RESP_NO_CHANGE   = 4'd3,
		RESP_BUSY        = 4'd4,
		RESP_DATA        = 4'd5,
		RESP_SEND_PROMPT = 4'd6,
		RESP_SEND_OK     = 4'd7,
		RESP_LINK_NOT    = 4'd8
	} resp_t;

	// Turns a string literal of n characters into a prefix, first character at index 0.
	function automatic prefix_t to_text(input logic [8*PREFIX_LEN-1:0] s, input int unsigned n);
		prefix_t t;
		t = '0;
		for (int unsigned i = 0; i < PREFIX_LEN; i++) begin
			if (i < n) begin
				t[i] = s[8*(n-1-i) +: 8];
			end
		end
		return t;
	endfunction

	// True when the first n bytes of s equal those of t.
	function automatic logic prefix_is(input prefix_t s, input prefix_t t, input int unsigned n);
		logic ok;
		ok = (n <= PREFIX_LEN);
		for (int unsigned i = 0; i < PREFIX_LEN; i++) begin
			if (i < n && s[i] != t[i]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	localparam prefix_t TEXT_IPD  = to_text("+IPD,", IPD_LEN);
	localparam prefix_t TEXT_OK   = to_text("OK", OK_LEN);
	localparam prefix_t TEXT_SEND = to_text("AT+CIPSEND=", SEND_CMD_LEN);

	localparam prefix_t REPLY_TEXT [REPLY_NUM] = '{
		to_text("ready", 5),
		to_text("OK", 2),
		to_text("ERROR", 5),
		to_text("no change", 9),
		to_text("busy", 4),
		to_text("busy now ...", 12),
		to_text("SEND OK", 7),
		to_text("link is not", 11)
	};

	localparam int unsigned REPLY_LEN [REPLY_NUM] = '{5, 2, 5, 9, 4, 12, 7, 11};

	localparam resp_t REPLY_CODE [REPLY_NUM] = '{
		RESP_READY, RESP_OK, RESP_ERROR, RESP_NO_CHANGE,
		RESP_BUSY, RESP_BUSY, RESP_SEND_OK, RESP_LINK_NOT
	};

endpackage

[sv/at_response_ipd_parser_unit.sv]
// Top level of the AT response and +IPD frame parser: input register, parse logic, result register.
// Depends on atipd_pkg for codes, reply texts and the prefix compare.
//
//   channel   handshake                   payload
//   byte      byte_valid / byte_stall     op, rx_byte
//   result    result_valid / result_stall kind, response, conn_id, frame_length,
//                                         payload_byte, payload_index, last_byte
//
// A request taken into the input register is parsed out of it, and any result loads into the
// result register unless a stalled result holds the request there; one request is taken
// per cycle while byte_stall is low.
// The combinational path between the registers is the parse step: the 12-byte prefix compare against the reply texts
// and the length accumulator's multiply by ten with its digit add.
// Reset (arst_n low) returns the parser to command mode with empty counters and a zero prefix.
// A stalled result holds the request in the input register, and byte_stall rises only then.
module at_response_ipd_parser_unit
	import atipd_pkg::*;
#(
	parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  rx_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [3:0]  response,
	output logic [7:0]  conn_id,
	output logic [15:0] frame_length,
	output logic [7:0]  payload_byte,
	output logic [15:0] payload_index,
	output logic        last_byte
);

	// Capture counters must hold the value LINE_DEPTH itself before they wrap.
	localparam int unsigned CW = $clog2(LINE_DEPTH + 1);

	// Input register.
	logic        in_vld_s1;
	logic [1:0]  op_s1;
	logic [7:0]  rx_s1;

	// Parser state.
	mode_t       mode_q, mode_n;
	logic [CW-1:0] lc_q, lc_n;
	logic [CW-1:0] sc_q, sc_n;
	prefix_t     store_q, store_n;
	logic [15:0] acc_q, acc_n;
	logic [15:0] exp_q, exp_n;
	logic [15:0] bp_q, bp_n;
	logic [7:0]  conn_q, conn_n;

	// Result register.
	logic        out_vld_q;
	kind_t       kind_q;
	resp_t       resp_q;
	logic [7:0]  conn_out_q;
	logic [15:0] len_out_q;
	logic [7:0]  pbyte_q;
	logic [15:0] pidx_q;
	logic        last_q;

	// A full result register that is stalled freezes the request waiting in the input register.
	logic out_hold;
	logic proc_go;

	assign out_hold   = out_vld_q & result_stall;
	assign proc_go    = in_vld_s1 & ~out_hold;
	assign byte_stall = in_vld_s1 & out_hold;

	// Line capture: splits on CR or LF, and also closes early on a "+IPD," prefix.
	logic [CW-1:0] lc_w;
	logic [CW-1:0] lc_after;
	logic [CW-1:0] line_len;
	prefix_t       store_line;
	logic          line_eol;
	logic          line_ipd;

	always_comb begin
		lc_w       = (lc_q >= CW'(LINE_DEPTH)) ? '0 : lc_q;
		store_line = store_q;
		if (lc_w < CW'(PREFIX_LEN)) begin
			store_line[lc_w[PREFIX_IW-1:0]] = rx_s1;
		end
		line_eol = (rx_s1 == ASCII_CR) || (rx_s1 == ASCII_LF);
		lc_after = line_eol ? '0 : lc_w + CW'(1);
		line_len = line_eol ? lc_w : '0;
		line_ipd = (lc_after == CW'(IPD_LEN)) && prefix_is(store_line, TEXT_IPD, IPD_LEN);
		if (line_ipd) begin
			line_len = CW'(IPD_LEN);
			lc_after = '0;
		end
	end

	// Reply match on a completed line. The reply lengths all differ where the texts could
	// both match, so at most one entry hits.
	logic  reply_hit;
	resp_t reply_code;

	always_comb begin
		reply_hit  = 1'b0;
		reply_code = RESP_READY;
		for (int unsigned k = 0; k < REPLY_NUM; k++) begin
			if (line_len == CW'(REPLY_LEN[k]) && prefix_is(store_line, REPLY_TEXT[k], REPLY_LEN[k])) begin
				reply_hit  = 1'b1;
				reply_code = REPLY_CODE[k];
			end
		end
	end

	// Split capture up to a key byte that depends on the mode. A key byte at the first
	// position of a field counts as data.
	logic [CW-1:0] sc_w;
	logic [CW-1:0] sc_after;
	prefix_t       store_split;
	logic [7:0]    split_key;
	logic          split_end;
	logic [15:0]   acc_base;
	logic [15:0]   acc_step;

	always_comb begin
		case (mode_q)
			MODE_ID:  split_key = KEY_COMMA;
			MODE_LEN: split_key = KEY_COLON;
			default:  split_key = KEY_PROMPT;
		endcase
		sc_w        = (sc_q >= CW'(LINE_DEPTH)) ? '0 : sc_q;
		store_split = store_q;
		if (sc_w < CW'(PREFIX_LEN)) begin
			store_split[sc_w[PREFIX_IW-1:0]] = rx_s1;
		end
		split_end = (sc_w != '0) && (rx_s1 == split_key);
		sc_after  = split_end ? '0 : sc_w + CW'(1);
		// Decimal length: every byte adds (byte - '0'), digit or not, modulo 2^16.
		acc_base  = (sc_w == '0) ? 16'd0 : acc_q;
		acc_step  = {acc_base[12:0], 3'b000} + {acc_base[14:0], 1'b0}
			+ {8'd0, rx_s1} - {8'd0, ASCII_ZERO};
	end

	// Parse step for the request in the input register.
	logic        res_vld;
	kind_t       res_kind;
	resp_t       res_resp;
	logic [7:0]  res_conn;
	logic [15:0] res_len;
	logic [7:0]  res_pbyte;
	logic [15:0] res_pidx;
	logic        res_last;

	always_comb begin
		mode_n    = mode_q;
		lc_n      = lc_q;
		sc_n      = sc_q;
		store_n   = store_q;
		acc_n     = acc_q;
		exp_n     = exp_q;
		bp_n      = bp_q;
		conn_n    = conn_q;
		res_vld   = 1'b0;
		res_kind  = KIND_RESPONSE;
		res_resp  = RESP_READY;
		res_conn  = '0;
		res_len   = '0;
		res_pbyte = '0;
		res_pidx  = '0;
		res_last  = 1'b0;
		case (op_s1)
			OP_ARM_SEND: begin
				mode_n = MODE_PROMPT;
			end
			OP_FORCE_CMD: begin
				mode_n = MODE_LINES;
			end
			OP_BYTE: begin
				case (mode_q)
					MODE_LINES: begin
						// Zero bytes never enter a line.
						if (rx_s1 != ASCII_NUL) begin
							lc_n    = lc_after;
							store_n = store_line;
							if (line_ipd) begin
								mode_n = MODE_ID;
							end
							if (reply_hit) begin
								res_vld  = 1'b1;
								res_resp = reply_code;
							end
						end
					end
					MODE_ID: begin
						sc_n    = sc_after;
						store_n = store_split;
						if (split_end) begin
							conn_n = store_split[0] - ASCII_ZERO;
							mode_n = MODE_LEN;
						end
					end
					MODE_LEN: begin
						sc_n    = sc_after;
						store_n = store_split;
						if (split_end) begin
							exp_n    = acc_q;
							bp_n     = '0;
							mode_n   = MODE_PAYLOAD;
							res_vld  = 1'b1;
							res_kind = KIND_HEADER;
							res_conn = conn_q;
							res_len  = acc_q;
						end else begin
							acc_n = acc_step;
						end
					end
					MODE_PAYLOAD: begin
						if (bp_q < exp_q) begin
							// Payload bytes pass through untouched, zero bytes included.
							bp_n      = bp_q + 16'd1;
							res_vld   = 1'b1;
							res_kind  = KIND_PAYLOAD;
							res_conn  = conn_q;
							res_len   = exp_q;
							res_pbyte = rx_s1;
							res_pidx  = bp_q;
							res_last  = (bp_q + 16'd1 == exp_q);
						end else if (rx_s1 != ASCII_NUL) begin
							// After the payload, either the closing OK line or a new frame.
							lc_n    = lc_after;
							store_n = store_line;
							if (line_ipd) begin
								mode_n = MODE_ID;
							end else if (line_len == CW'(OK_LEN)
								&& prefix_is(store_line, TEXT_OK, OK_LEN)) begin
								mode_n   = MODE_LINES;
								res_vld  = 1'b1;
								res_resp = RESP_DATA;
							end
						end
					end
					MODE_PROMPT: begin
						sc_n    = sc_after;
						store_n = store_split;
						if (split_end && sc_w > CW'(SEND_MIN_LEN)
							&& prefix_is(store_split, TEXT_SEND, SEND_CMD_LEN)) begin
							mode_n   = MODE_LINES;
							res_vld  = 1'b1;
							res_resp = RESP_SEND_PROMPT;
						end
					end
					default: begin
						mode_n = MODE_LINES;
					end
				endcase
			end
			default: begin
				// The unused op code changes nothing.
			end
		endcase
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (!byte_stall) begin
			in_vld_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			op_s1 <= op;
			rx_s1 <= rx_byte;
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_LINES;
			lc_q    <= '0;
			sc_q    <= '0;
			store_q <= '0;
			acc_q   <= '0;
			exp_q   <= '0;
			bp_q    <= '0;
			conn_q  <= '0;
		end else if (proc_go) begin
			mode_q  <= mode_n;
			lc_q    <= lc_n;
			sc_q    <= sc_n;
			store_q <= store_n;
			acc_q   <= acc_n;
			exp_q   <= exp_n;
			bp_q    <= bp_n;
			conn_q  <= conn_n;
		end
	end

	// Result register. It refills in the same cycle that its old content is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_hold) begin
			out_vld_q <= proc_go & res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_go && res_vld) begin
			kind_q     <= res_kind;
			resp_q     <= res_resp;
			conn_out_q <= res_conn;
			len_out_q  <= res_len;
			pbyte_q    <= res_pbyte;
			pidx_q     <= res_pidx;
			last_q     <= res_last;
		end
	end

	assign result_valid  = out_vld_q;
	assign kind          = kind_q;
	assign response      = resp_q;
	assign conn_id       = conn_out_q;
	assign frame_length  = len_out_q;
	assign payload_byte  = pbyte_q;
	assign payload_index = pidx_q;
	assign last_byte     = last_q;

`ifndef SYNTHESIS
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bp_q <= exp_q)
		else $error("payload position ran past the frame length");

	a_payload_step: assert property (@(posedge clk) disable iff (!arst_n)
		(proc_go && res_vld && res_kind == KIND_PAYLOAD) |=> bp_q == $past(bp_q) + 16'd1)
		else $error("payload result without a position step");

	a_header_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(proc_go && res_vld && res_kind == KIND_HEADER) |=> mode_q == MODE_PAYLOAD && bp_q == '0)
		else $error("frame header did not start the payload");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (out_vld_q && in_vld_s1))
		else $error("request stalled while the result register can move");
`endif

endmodule
